@@ design/rps_pkg.sv @@
package rps_pkg;

  localparam int ACC_W = 140;

  localparam logic [1:0] K_ADD    = 2'd0;
  localparam logic [1:0] K_REMOVE = 2'd1;
  localparam logic [1:0] K_CLEAR  = 2'd2;
  localparam logic [1:0] K_PICK   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // microcode step numbers
  localparam logic [4:0] STEP_DOT      = 5'd3;
  localparam logic [4:0] STEP_CC       = 5'd6;
  localparam logic [4:0] STEP_M2       = 5'd7;
  localparam logic [4:0] STEP_LAST     = 5'd25;
  localparam logic [4:0] STEP_LEN0     = 5'd26;
  localparam logic [4:0] STEP_LEN_LAST = 5'd28;

  typedef enum logic [3:0] {
    S_IDLE, S_RM_RD, S_RM_WR, S_LEN, S_LCHK, S_FETCH, S_LOAD, S_RUN, S_DEC, S_NEXT, S_RESP
  } state_t;

  typedef enum logic [2:0] {
    SRC_CD, SRC_CC, SRC_DM, SRC_MM, SRC_CCL, SRC_DD, SRC_M2L
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [1:0] li;
    logic [1:0] lj;
    logic [7:0] sh;
    logic       sub;
    logic       clr;
  } ustep_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] half;
  } sprite_t;

  typedef struct packed {
    logic [2:0][32:0] cm;
    logic [2:0]       cs;
    logic [2:0][31:0] dm;
    logic [2:0]       ds;
    logic [95:0]      cc;
    logic [95:0]      dot;
    logic [30:0]      m;
    logic [63:0]      m2;
    logic [63:0]      len;
  } mac_ops_t;

  function automatic ustep_t mk(src_t s, logic [1:0] i, logic [1:0] j, logic [7:0] sh,
                                logic sub, logic clr);
    ustep_t u;
    u.src = s;
    u.li  = i;
    u.lj  = j;
    u.sh  = sh;
    u.sub = sub;
    u.clr = clr;
    return u;
  endfunction

  // Per entry: dot (0-2), |c|^2 (3-5), m^2 (6),
  // then 4*cc*L - 4*dot^2 - m^2*L over 32-bit limbs (7-25). Ray length (26-28).
  function automatic ustep_t ustep_f(logic [4:0] s);
    ustep_t u;
    case (s)
      5'd0:  u = mk(SRC_CD,  2'd0, 2'd0, 8'd0,   1'b0, 1'b1);
      5'd1:  u = mk(SRC_CD,  2'd1, 2'd0, 8'd0,   1'b0, 1'b0);
      5'd2:  u = mk(SRC_CD,  2'd2, 2'd0, 8'd0,   1'b0, 1'b0);
      5'd3:  u = mk(SRC_CC,  2'd0, 2'd0, 8'd0,   1'b0, 1'b1);
      5'd4:  u = mk(SRC_CC,  2'd1, 2'd0, 8'd0,   1'b0, 1'b0);
      5'd5:  u = mk(SRC_CC,  2'd2, 2'd0, 8'd0,   1'b0, 1'b0);
      5'd6:  u = mk(SRC_MM,  2'd0, 2'd0, 8'd0,   1'b0, 1'b1);
      5'd7:  u = mk(SRC_CCL, 2'd0, 2'd0, 8'd2,   1'b0, 1'b1);
      5'd8:  u = mk(SRC_CCL, 2'd0, 2'd1, 8'd34,  1'b0, 1'b0);
      5'd9:  u = mk(SRC_CCL, 2'd1, 2'd0, 8'd34,  1'b0, 1'b0);
      5'd10: u = mk(SRC_CCL, 2'd1, 2'd1, 8'd66,  1'b0, 1'b0);
      5'd11: u = mk(SRC_CCL, 2'd2, 2'd0, 8'd66,  1'b0, 1'b0);
      5'd12: u = mk(SRC_CCL, 2'd2, 2'd1, 8'd98,  1'b0, 1'b0);
      5'd13: u = mk(SRC_DD,  2'd0, 2'd0, 8'd2,   1'b1, 1'b0);
      5'd14: u = mk(SRC_DD,  2'd0, 2'd1, 8'd34,  1'b1, 1'b0);
      5'd15: u = mk(SRC_DD,  2'd0, 2'd2, 8'd66,  1'b1, 1'b0);
      5'd16: u = mk(SRC_DD,  2'd1, 2'd0, 8'd34,  1'b1, 1'b0);
      5'd17: u = mk(SRC_DD,  2'd1, 2'd1, 8'd66,  1'b1, 1'b0);
      5'd18: u = mk(SRC_DD,  2'd1, 2'd2, 8'd98,  1'b1, 1'b0);
      5'd19: u = mk(SRC_DD,  2'd2, 2'd0, 8'd66,  1'b1, 1'b0);
      5'd20: u = mk(SRC_DD,  2'd2, 2'd1, 8'd98,  1'b1, 1'b0);
      5'd21: u = mk(SRC_DD,  2'd2, 2'd2, 8'd130, 1'b1, 1'b0);
      5'd22: u = mk(SRC_M2L, 2'd0, 2'd0, 8'd0,   1'b1, 1'b0);
      5'd23: u = mk(SRC_M2L, 2'd0, 2'd1, 8'd32,  1'b1, 1'b0);
      5'd24: u = mk(SRC_M2L, 2'd1, 2'd0, 8'd32,  1'b1, 1'b0);
      5'd25: u = mk(SRC_M2L, 2'd1, 2'd1, 8'd64,  1'b1, 1'b0);
      5'd26: u = mk(SRC_DM,  2'd0, 2'd0, 8'd0,   1'b0, 1'b1);
      5'd27: u = mk(SRC_DM,  2'd1, 2'd0, 8'd0,   1'b0, 1'b0);
      5'd28: u = mk(SRC_DM,  2'd2, 2'd0, 8'd0,   1'b0, 1'b0);
      default: u = mk(SRC_CD, 2'd0, 2'd0, 8'd0,  1'b0, 1'b0);
    endcase
    return u;
  endfunction

endpackage

@@ design/rps_if.sv @@
interface rps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [30:0]        width_size;
  logic [30:0]        height_size;
  logic [5:0]         entry_index;

  modport source (output valid, kind, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                  width_size, height_size, entry_index, input ready);
  modport sink (input valid, kind, point_x, point_y, point_z, dir_x, dir_y, dir_z,
                width_size, height_size, entry_index, output ready);
endinterface

interface rps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       hit_found;
  logic [5:0] hit_index;
  logic [6:0] entry_count;

  modport source (output valid, status, hit_found, hit_index, entry_count, input ready);
  modport sink (input valid, status, hit_found, hit_index, entry_count, output ready);
endinterface

@@ design/rps_store.sv @@
module rps_store #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  rps_pkg::sprite_t    wdata,
  input  logic [IW-1:0]       raddr,
  output rps_pkg::sprite_t    rdata
);
  import rps_pkg::*;

  sprite_t mem [DEPTH];
  sprite_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/rps_mac.sv @@
module rps_mac (
  input  logic                       clk,
  input  logic                       en,
  input  logic [4:0]                 step,
  input  rps_pkg::mac_ops_t          ops,
  output logic [rps_pkg::ACC_W-1:0]  acc
);
  import rps_pkg::*;

  ustep_t           u;
  logic [32:0]      op_a;
  logic [32:0]      op_b;
  logic [65:0]      prod;
  logic [ACC_W-1:0] term;
  logic [ACC_W-1:0] base;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             sub;

  always_comb begin
    u    = ustep_f(step);
    op_a = '0;
    op_b = '0;
    sub  = u.sub;
    case (u.src)
      SRC_CD: begin
        op_a = ops.cm[u.li];
        op_b = {1'b0, ops.dm[u.li]};
        sub  = ops.cs[u.li] ^ ops.ds[u.li];
      end
      SRC_CC: begin
        op_a = ops.cm[u.li];
        op_b = ops.cm[u.li];
      end
      SRC_DM: begin
        op_a = {1'b0, ops.dm[u.li]};
        op_b = {1'b0, ops.dm[u.li]};
      end
      SRC_MM: begin
        op_a = {2'b0, ops.m};
        op_b = {2'b0, ops.m};
      end
      SRC_CCL: begin
        op_a = {1'b0, ops.cc[{u.li, 5'b0} +: 32]};
        op_b = {1'b0, ops.len[{u.lj[0], 5'b0} +: 32]};
      end
      SRC_DD: begin
        op_a = {1'b0, ops.dot[{u.li, 5'b0} +: 32]};
        op_b = {1'b0, ops.dot[{u.lj, 5'b0} +: 32]};
      end
      SRC_M2L: begin
        op_a = {1'b0, ops.m2[{u.li[0], 5'b0} +: 32]};
        op_b = {1'b0, ops.len[{u.lj[0], 5'b0} +: 32]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod    = op_a * op_b;
    term    = {{(ACC_W-66){1'b0}}, prod} << u.sh;
    base    = u.clr ? '0 : acc_r;
    acc_nxt = sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ design/ray_pick_sprite_table.sv @@
// Ray-pick sprite table.
// in_if  : one item per handshake (valid & ready). kind selects add, remove at
//          index, clear, or pick with a ray. in_if.ready is high only while the
//          sequencer is idle; the block works on one item at a time.
// out_if : exactly one result item per input item, held in an output register
//          until taken. A new input is accepted while a result still waits; the
//          finished result of that next item then waits until the slot frees.
// Sequence from accept to out valid:
//   add, clear, rejected remove: straight to the response state.
//   remove: one store read and one write per entry shifted down (S_RM_RD, S_RM_WR).
//   pick: the ray-length steps, then per held entry S_FETCH, S_LOAD, S_RUN, S_DEC and
//     S_NEXT. Each entry goes through one shared 33x33 multiplier and 140-bit accumulator
//     for 26 steps; an entry behind the origin drops out after the dot product.
// Reset clears the entry count and the sequencer; the store itself is not
// cleared, since only entries below the count are ever read.
module ray_pick_sprite_table #(
  parameter int MAX_SPRITES = 64
) (
  input logic     clk,
  input logic     rst_n,
  rps_in_if.sink  in_if,
  rps_out_if.source out_if
);
  import rps_pkg::*;

  localparam int IW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
  localparam int CW = $clog2(MAX_SPRITES + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          res_found_r, res_found_nxt;
  logic [IW-1:0] res_hit_r, res_hit_nxt;
  logic          out_valid_r, out_valid_nxt;

  // datapath registers
  mac_ops_t         ops_r, ops_nxt;
  logic [2:0][31:0] org_r, org_nxt;
  logic [95:0]      best_r, best_nxt;
  logic [1:0]       out_status_r;
  logic             out_found_r;
  logic [5:0]       out_hit_r;
  logic [6:0]       out_count_r;

  logic             in_acc;
  logic             out_load;
  logic             mac_en;
  logic [ACC_W-1:0] acc;
  logic             acc_nonpos;

  logic             st_we;
  logic [IW-1:0]    st_waddr;
  sprite_t          st_wdata;
  logic [IW-1:0]    st_raddr;
  sprite_t          st_rdata;

  logic [CW+5:0]    idx_ext;
  logic [CW+5:0]    cnt_ext;
  logic [IW+5:0]    hit_ext;
  logic [CW+6:0]    cnt_out_ext;
  logic [2:0][31:0] cen;
  logic [2:0][32:0] cdiff;
  logic [2:0][32:0] cmag;
  logic [2:0][31:0] dir;

  rps_store #(.DEPTH(MAX_SPRITES), .IW(IW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rps_mac u_mac (
    .clk  (clk),
    .en   (mac_en),
    .step (step_r),
    .ops  (ops_r),
    .acc  (acc)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign acc_nonpos  = acc[ACC_W-1] || (acc == '0);

  assign idx_ext     = {{CW{1'b0}}, in_if.entry_index};
  assign cnt_ext     = {6'b0, count_r};
  assign hit_ext     = {6'b0, res_hit_r};
  assign cnt_out_ext = {7'b0, count_r};

  // centre minus origin, with sign-magnitude split for the multiplier
  always_comb begin
    cen[0] = st_rdata.x;
    cen[1] = st_rdata.y;
    cen[2] = st_rdata.z;
    dir[0] = in_if.dir_x;
    dir[1] = in_if.dir_y;
    dir[2] = in_if.dir_z;
    for (int k = 0; k < 3; k++) begin
      cdiff[k] = {cen[k][31], cen[k]} - {org_r[k][31], org_r[k]};
      cmag[k]  = cdiff[k][32] ? (~cdiff[k] + 33'd1) : cdiff[k];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_hit_nxt    = res_hit_r;
    ops_nxt        = ops_r;
    org_nxt        = org_r;
    best_nxt       = best_r;
    mac_en         = 1'b0;
    out_load       = 1'b0;
    st_we          = 1'b0;
    st_waddr       = count_r[IW-1:0];
    st_wdata.x     = in_if.point_x;
    st_wdata.y     = in_if.point_y;
    st_wdata.z     = in_if.point_z;
    st_wdata.half  = (in_if.width_size > in_if.height_size) ? in_if.width_size
                                                            : in_if.height_size;
    st_raddr       = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_hit_nxt    = '0;
          state_nxt      = S_RESP;
          case (in_if.kind)
            K_ADD: begin
              if (count_r >= CW'(MAX_SPRITES)) begin
                res_status_nxt = ST_FULL;
              end else begin
                st_we     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            K_REMOVE: begin
              if (idx_ext >= cnt_ext) begin
                res_status_nxt = ST_BAD;
              end else if (idx_ext + (CW+6)'(1) >= cnt_ext) begin
                count_nxt = count_r - CW'(1);
              end else begin
                idx_nxt   = idx_ext[IW-1:0];
                state_nxt = S_RM_RD;
              end
            end
            K_CLEAR: begin
              count_nxt = '0;
            end
            K_PICK: begin
              org_nxt[0] = in_if.point_x;
              org_nxt[1] = in_if.point_y;
              org_nxt[2] = in_if.point_z;
              for (int k = 0; k < 3; k++) begin
                ops_nxt.ds[k] = dir[k][31];
                ops_nxt.dm[k] = dir[k][31] ? (~dir[k] + 32'd1) : dir[k];
              end
              step_nxt  = STEP_LEN0;
              state_nxt = S_LEN;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_RM_RD: begin
        st_raddr  = idx_r + IW'(1);
        state_nxt = S_RM_WR;
      end

      S_RM_WR: begin
        st_we    = 1'b1;
        st_waddr = idx_r;
        st_wdata = st_rdata;
        idx_nxt  = idx_r + IW'(1);
        if (CW'(idx_r) + CW'(2) < count_r) begin
          state_nxt = S_RM_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_LEN: begin
        mac_en   = 1'b1;
        step_nxt = step_r + 5'd1;
        if (step_r == STEP_LEN_LAST) begin
          state_nxt = S_LCHK;
        end
      end

      S_LCHK: begin
        ops_nxt.len = acc[63:0];
        idx_nxt     = '0;
        if (acc[63:0] == 64'd0 || count_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_FETCH;
        end
      end

      S_FETCH: begin
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          ops_nxt.cm[k] = cmag[k];
          ops_nxt.cs[k] = cdiff[k][32];
        end
        ops_nxt.m = st_rdata.half;
        step_nxt  = '0;
        state_nxt = S_RUN;
      end

      S_RUN: begin
        if (step_r == STEP_DOT && acc_nonpos) begin
          // sprite is not ahead of the origin
          state_nxt = S_NEXT;
        end else begin
          mac_en   = 1'b1;
          step_nxt = step_r + 5'd1;
          if (step_r == STEP_DOT) begin
            ops_nxt.dot = acc[95:0];
          end
          if (step_r == STEP_CC) begin
            ops_nxt.cc = acc[95:0];
          end
          if (step_r == STEP_M2) begin
            ops_nxt.m2 = acc[63:0];
          end
          if (step_r == STEP_LAST) begin
            state_nxt = S_DEC;
          end
        end
      end

      S_DEC: begin
        if (acc_nonpos && (!res_found_r || ops_r.dot < best_r)) begin
          res_found_nxt = 1'b1;
          res_hit_nxt   = idx_r;
          best_nxt      = ops_r.dot;
        end
        state_nxt = S_NEXT;
      end

      S_NEXT: begin
        if (CW'(idx_r) + CW'(1) == count_r) begin
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_FETCH;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      step_r       <= '0;
      res_status_r <= ST_OK;
      res_found_r  <= 1'b0;
      res_hit_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      step_r       <= step_nxt;
      res_status_r <= res_status_nxt;
      res_found_r  <= res_found_nxt;
      res_hit_r    <= res_hit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ops_r  <= ops_nxt;
    org_r  <= org_nxt;
    best_r <= best_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_hit_r    <= hit_ext[5:0];
      out_count_r  <= cnt_out_ext[6:0];
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.hit_found   = out_found_r;
  assign out_if.hit_index   = out_hit_r;
  assign out_if.entry_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SPRITES))
    else $error("entry count above table size");

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN || state_r == S_DEC) |-> (CW'(idx_r) < count_r))
    else $error("pick walked past held entries");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && res_found_r) |-> (CW'(res_hit_r) < count_r))
    else $error("hit index not a held entry");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.kind == K_CLEAR) |=> (count_r == '0 && state_r == S_RESP))
    else $error("clear did not empty table");

endmodule

@@ test/rps_test_if.sv @@
// Channel interfaces are defined in the design; nothing extra is needed here.
// The testbench drives the design interfaces rps_in_if and rps_out_if directly.
package rps_test_pkg;
  import rps_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] dx, dy, dz;
    logic [30:0]        wsz, hsz;
    logic [5:0]         idx;
  } sprite_cmd_t;

  typedef struct {
    logic [1:0] status;
    logic       found;
    logic [5:0] hit;
    logic [6:0] count;
  } pick_result_t;
endpackage

@@ test/ray_pick_sprite_table_test.sv @@
module ray_pick_sprite_table_test;
  import rps_pkg::*;
  import rps_test_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rps_in_if  cmd_ch ();
  rps_out_if res_ch ();

  ray_pick_sprite_table dut (.clk(clk), .rst_n(rst_n), .in_if(cmd_ch), .out_if(res_ch));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the sprite table.
  logic signed [31:0] tbl_x [DEPTH];
  logic signed [31:0] tbl_y [DEPTH];
  logic signed [31:0] tbl_z [DEPTH];
  logic [30:0]        tbl_half [DEPTH];
  int                 tbl_count = 0;

  sprite_cmd_t  pending_cmds[$];
  pick_result_t expected_results[$];
  int           fail_count = 0;
  int           send_idle_pct, take_idle_pct;
  bit           hold_sender;   // pause sending while set
  bit           stimulus_done;
  int           quiet_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void queue_cmd(input sprite_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void queue_expect(input pick_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Apply one command to the shadow table and return what the block must answer.
  function automatic pick_result_t apply_command(input sprite_cmd_t c);
    pick_result_t r;
    logic signed [33:0] cv [3];
    logic signed [33:0] dv [3];
    logic signed [33:0] ov [3];
    logic [191:0] len2, cc, best, lhs, rhs, m;
    logic signed [191:0] dot;
    r = '{ST_OK, 1'b0, 6'd0, 7'd0};
    best = '0;
    case (c.kind)
      K_ADD: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_x[tbl_count] = c.px;
          tbl_y[tbl_count] = c.py;
          tbl_z[tbl_count] = c.pz;
          tbl_half[tbl_count] = (c.wsz > c.hsz) ? c.wsz : c.hsz;
          tbl_count++;
        end
      end
      K_REMOVE: begin
        if (c.idx >= tbl_count) begin
          r.status = ST_BAD;
        end else begin
          for (int i = c.idx; i + 1 < tbl_count; i++) begin
            tbl_x[i] = tbl_x[i+1];
            tbl_y[i] = tbl_y[i+1];
            tbl_z[i] = tbl_z[i+1];
            tbl_half[i] = tbl_half[i+1];
          end
          tbl_count--;
        end
      end
      K_CLEAR: tbl_count = 0;
      default: begin
        ov[0] = c.px; ov[1] = c.py; ov[2] = c.pz;
        dv[0] = c.dx; dv[1] = c.dy; dv[2] = c.dz;
        len2 = '0;
        for (int k = 0; k < 3; k++) len2 += 192'($signed(dv[k]) * $signed(dv[k]));
        if (len2 != 0) begin
          for (int i = 0; i < tbl_count; i++) begin
            cv[0] = 34'(tbl_x[i]) - ov[0];
            cv[1] = 34'(tbl_y[i]) - ov[1];
            cv[2] = 34'(tbl_z[i]) - ov[2];
            dot = '0;
            cc = '0;
            for (int k = 0; k < 3; k++) begin
              dot += 192'($signed(cv[k])) * 192'($signed(dv[k]));
              cc += 192'($signed(cv[k]) * $signed(cv[k]));
            end
            if (dot <= 0) continue;
            // 4*(cc*L - dot^2) <= half^2 * L, exact
            lhs = (cc * len2 - 192'(dot) * 192'(dot)) << 2;
            m = 192'(tbl_half[i]);
            rhs = m * m * len2;
            if (lhs > rhs) continue;
            if (!r.found || 192'(dot) < best) begin
              r.found = 1'b1;
              r.hit = 6'(i);
              best = 192'(dot);
            end
          end
        end
      end
    endcase
    r.count = 7'(tbl_count);
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(0, 4))
      0: return 31'h7fff_ffff;
      1: return 31'($urandom);
      2: return 31'd0;
      default: return 31'($urandom_range(0, 3000000));
    endcase
  endfunction

  function automatic sprite_cmd_t make_cmd(input logic [1:0] kind);
    sprite_cmd_t c;
    c.kind = kind;
    c.px = rand_coord(); c.py = rand_coord(); c.pz = rand_coord();
    c.dx = rand_coord(); c.dy = rand_coord(); c.dz = rand_coord();
    c.wsz = rand_size(); c.hsz = rand_size();
    c.idx = 6'($urandom);
    return c;
  endfunction

  // Pick aimed at a chosen sprite from a nearby origin so hits actually occur.
  function automatic sprite_cmd_t aimed_pick(input int n);
    sprite_cmd_t c;
    int t;
    c = make_cmd(K_PICK);
    if (n > 0) begin
      t = $urandom_range(0, n - 1);
      c.px = tbl_x[t] - 32'sd300000;
      c.py = tbl_y[t] + 32'($signed($urandom_range(0, 20)) - 10);
      c.pz = tbl_z[t];
      c.dx = 32'sd65536 * $urandom_range(1, 4);
      c.dy = $urandom_range(0, 1) ? 32'sd0 : 32'($signed($urandom_range(0, 100)) - 50);
      c.dz = 32'sd0;
    end
    return c;
  endfunction

  // Driver: one nonblocking assignment per signal per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() != 0 && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          sprite_cmd_t c;
          c = pending_cmds.pop_front();
          queue_expect(apply_command(c));
          cmd_ch.valid <= 1'b1;
          cmd_ch.kind <= c.kind;
          cmd_ch.point_x <= c.px; cmd_ch.point_y <= c.py; cmd_ch.point_z <= c.pz;
          cmd_ch.dir_x <= c.dx; cmd_ch.dir_y <= c.dy; cmd_ch.dir_z <= c.dz;
          cmd_ch.width_size <= c.wsz; cmd_ch.height_size <= c.hsz;
          cmd_ch.entry_index <= c.idx;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: ready toggles at random; results are checked on the handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          pick_result_t w;
          w = expected_results.pop_front();
          if (res_ch.status !== w.status) report_mismatch("status", res_ch.status, w.status);
          if (res_ch.hit_found !== w.found) report_mismatch("hit_found", res_ch.hit_found, w.found);
          if (res_ch.hit_index !== w.hit) report_mismatch("hit_index", res_ch.hit_index, w.hit);
          if (res_ch.entry_count !== w.count)
            report_mismatch("entry_count", res_ch.entry_count, w.count);
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Fills one phase; picks are built against the table state predicted so far.
  task automatic random_phase(input int n);
    int cnt;
    int r;
    sprite_cmd_t c;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      wait_drained();
      cnt = tbl_count;
      r = $urandom_range(0, 99);
      if (r < 45) c = make_cmd(K_ADD);
      else if (r < 60) c = make_cmd(K_REMOVE);
      else if (r < 62) c = make_cmd(K_CLEAR);
      else if (r < 85) c = aimed_pick(cnt);
      else c = make_cmd(K_PICK);
      if (c.kind == K_REMOVE && cnt > 0 && $urandom_range(0, 3) != 0)
        c.idx = 6'($urandom_range(0, cnt - 1));
      queue_cmd(c);
    end
  endtask

  initial begin
    sprite_cmd_t c;
    hold_sender = 1'b0;
    send_idle_pct = 17;
    take_idle_pct = 56;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table cases, extremes, zero direction, ties, full table.
    c = make_cmd(K_REMOVE); c.idx = 6'd0; queue_cmd(c);                // bad index
    c = make_cmd(K_CLEAR); queue_cmd(c);                               // clear empty
    c = make_cmd(K_PICK); queue_cmd(c);                                // pick empty
    c = make_cmd(K_ADD);
    c.px = 32'sh8000_0000; c.py = 32'sh7fff_ffff; c.pz = 0;
    c.wsz = 31'h7fff_ffff; c.hsz = 31'd0;
    queue_cmd(c);
    c.px = 32'sh7fff_ffff; c.py = 32'sh8000_0000; c.pz = 32'sh8000_0000;
    c.wsz = 31'd0; c.hsz = 31'h7fff_ffff;
    queue_cmd(c);
    c.px = 32'sd65536; c.py = 0; c.pz = 0; c.wsz = 31'd65536; c.hsz = 31'd65536;
    queue_cmd(c);
    queue_cmd(c);                                                      // duplicate -> tie
    c = make_cmd(K_PICK);
    c.px = 32'sh8000_0000; c.py = 32'sh8000_0000; c.pz = 32'sh8000_0000;
    c.dx = 32'sh7fff_ffff; c.dy = 32'sh7fff_ffff; c.dz = 32'sh7fff_ffff;
    queue_cmd(c);
    c.px = 0; c.py = 0; c.pz = 0; c.dx = 32'sd65536; c.dy = 0; c.dz = 0;
    queue_cmd(c);                                                      // tie
    c.dx = 32'sh8000_0000; queue_cmd(c);                               // behind
    c.dx = 0; queue_cmd(c);                                            // zero direction
    c = make_cmd(K_REMOVE); c.idx = 6'd63; queue_cmd(c);               // out of range
    c.idx = 6'd1; queue_cmd(c);
    for (int i = 0; i < 66; i++) queue_cmd(make_cmd(K_ADD));           // to full
    c = make_cmd(K_REMOVE); c.idx = 6'd63; queue_cmd(c);
    c.idx = 6'd0; queue_cmd(c);
    queue_cmd(make_cmd(K_PICK));
    c = make_cmd(K_CLEAR); queue_cmd(c);

    // Drain with the sender held back.
    wait_drained();
    hold_sender = 1'b1;
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;

    random_phase(240);
    wait_drained();
    send_idle_pct = 56;
    take_idle_pct = 17;
    random_phase(240);
    wait_drained();
    send_idle_pct = 0;
    take_idle_pct = 0;
    random_phase(240);
    wait_drained();
    repeat (50) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
